@@ rtl/md5_digest_engine_top_defines.svh @@
// Assertion macros shared by the MD5 digest engine RTL.
`ifndef MD5_DIGEST_ENGINE_TOP_DEFINES_SVH
`define MD5_DIGEST_ENGINE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante (clk and arst_n in scope).
`define MD5DE_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MD5DE_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/md5de_pkg.sv @@
// Types, constants, round tables and the control program of the MD5 digest engine.
`default_nettype none

package md5de_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [5:0]  ROUND_LAST = 6'd63;
	localparam logic [5:0]  BLOCK_LAST_POS = 6'd63;
	localparam logic [5:0]  LEN_ROOM_POS = 6'd56;
	localparam int          COUNT_W = 61;
	localparam int          STEP_W = 5;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP   = 4'd0,
		OP_TAKE  = 4'd1,
		OP_LOAD  = 4'd2,
		OP_ROUND = 4'd3,
		OP_ADD   = 4'd4,
		OP_PAD   = 4'd5,
		OP_CLEAR = 4'd6,
		OP_LEN   = 4'd7,
		OP_EMIT0 = 4'd8,
		OP_EMIT1 = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		CND_NEXT     = 3'd0,
		CND_GOTO     = 3'd1,
		CND_WAIT_IN  = 3'd2,
		CND_WAIT_OUT = 3'd3,
		CND_LOOP     = 3'd4,
		CND_IF_NFULL = 3'd5,
		CND_IF_NEND  = 3'd6,
		CND_IF_SHORT = 3'd7
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctl_word_t;

	localparam step_t STEP_TAKE  = 5'd0;
	localparam step_t STEP_DISP  = 5'd1;
	localparam step_t STEP_ENDCK = 5'd5;
	localparam step_t STEP_LEN   = 5'd11;
	localparam step_t STEP_LAST  = 5'd16;

	// Control store: one word per step.
	function automatic ctl_word_t ucode(input step_t step);
		ctl_word_t w;
		case (step)
			5'd0:    w = '{OP_TAKE,  CND_WAIT_IN,  STEP_DISP};
			5'd1:    w = '{OP_NOP,   CND_IF_NFULL, STEP_ENDCK};
			5'd2:    w = '{OP_LOAD,  CND_NEXT,     STEP_TAKE};
			5'd3:    w = '{OP_ROUND, CND_LOOP,     5'd4};
			5'd4:    w = '{OP_ADD,   CND_NEXT,     STEP_TAKE};
			5'd5:    w = '{OP_NOP,   CND_IF_NEND,  STEP_TAKE};
			5'd6:    w = '{OP_PAD,   CND_IF_SHORT, STEP_LEN};
			5'd7:    w = '{OP_LOAD,  CND_NEXT,     STEP_TAKE};
			5'd8:    w = '{OP_ROUND, CND_LOOP,     5'd9};
			5'd9:    w = '{OP_ADD,   CND_NEXT,     STEP_TAKE};
			5'd10:   w = '{OP_CLEAR, CND_NEXT,     STEP_TAKE};
			5'd11:   w = '{OP_LEN,   CND_NEXT,     STEP_TAKE};
			5'd12:   w = '{OP_LOAD,  CND_NEXT,     STEP_TAKE};
			5'd13:   w = '{OP_ROUND, CND_LOOP,     5'd14};
			5'd14:   w = '{OP_ADD,   CND_NEXT,     STEP_TAKE};
			5'd15:   w = '{OP_EMIT0, CND_WAIT_OUT, STEP_LAST};
			5'd16:   w = '{OP_EMIT1, CND_WAIT_OUT, STEP_TAKE};
			default: w = '{OP_NOP,   CND_GOTO,     STEP_TAKE};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] sine_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Rotation amount, indexed by {round group, round[1:0]}.
	function automatic logic [4:0] rot_amount(input logic [3:0] sel);
		logic [4:0] s;
		case (sel)
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	// Message word used by round r; arithmetic wraps modulo 16.
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] lo;
		logic [3:0] g;
		lo = r[3:0];
		case (r[5:4])
			2'd0:    g = lo;
			2'd1:    g = lo * 4'd5 + 4'd1;
			2'd2:    g = lo * 4'd3 + 4'd5;
			default: g = lo * 4'd7;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] round_fn(input logic [1:0] grp, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		case (grp)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ rtl/md5_digest_engine_top.sv @@
// MD5 digest engine: byte stream in, two 64-bit digest halves out.
`default_nettype none
`include "md5_digest_engine_top_defines.svh"

// Computes MD5 over a stream of items, each carrying at most one message byte
// (s_tuser high) and optionally closing the message (s_tlast high). On close
// the engine pads, appends the 64-bit bit length and presents the digest as
// two items on the master side: bytes 0-7 first (m_tlast low), then bytes
// 8-15 (m_tlast high), first digest byte in bits 7:0. It then returns to the
// initial chaining values for the next message. Control is a 17-step program
// in a constant control store; one round unit does one MD5 round per cycle.
// Item flow, set by that round unit and the control program:
//   - item neither completing a block nor closing: take, dispatch, end check;
//   - item whose byte fills a 64-byte block: 64 rounds plus load, add and
//     dispatch;
//   - close adds padding, an extra load, rounds, add and clear (only when
//     fewer than nine bytes of room are left in the block), then the length,
//     load, rounds and add, then each digest half once the master can take it.
// The output register lets the next message start while the last digest half
// still waits on m_tready.
module md5_digest_engine_top
	import md5de_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] byte_present
	input  wire logic        s_tlast,   // end_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] digest_half
	output logic             m_tlast    // last_half
);

	ctl_word_t           ctl;
	step_t               step_q;
	step_t               step_d;
	logic [31:0]         chain_q [4];
	logic [31:0]         block_q [16];
	logic [31:0]         rw_q [4];
	logic [COUNT_W-1:0]  count_q;
	logic [5:0]          round_q;
	logic                full_q;
	logic                end_q;
	logic                out_valid_q;
	logic [63:0]         out_data_q;
	logic                out_last_q;

	logic                in_acc;
	logic                out_free;
	logic                round_done;
	logic [5:0]          pos;
	logic [31:0]         f_val;
	logic [31:0]         sum_val;
	logic [63:0]         rot_wide;
	logic [31:0]         new_b;
	logic [63:0]         bit_len;

	// Fetch the control word for the current step.
	assign ctl = ucode(step_q);

	assign s_tready   = (ctl.op == OP_TAKE);
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign round_done = (round_q == ROUND_LAST);
	assign pos        = count_q[5:0];
	assign bit_len    = {count_q, 3'b000};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// One MD5 round: F + A + K + M, rotate, add B.
	always_comb begin
		f_val    = round_fn(round_q[5:4], rw_q[1], rw_q[2], rw_q[3]);
		sum_val  = f_val + rw_q[0] + sine_k(round_q) + block_q[msg_index(round_q)];
		rot_wide = {sum_val, sum_val} << rot_amount({round_q[5:4], round_q[1:0]});
		new_b    = rw_q[1] + rot_wide[63:32];
	end

	// Sequencer: pick the next step from the jump condition.
	always_comb begin
		step_d = step_q;
		case (ctl.cond)
			CND_NEXT:     step_d = step_q + 1'b1;
			CND_GOTO:     step_d = ctl.target;
			CND_WAIT_IN:  step_d = in_acc ? ctl.target : step_q;
			CND_WAIT_OUT: step_d = out_free ? ctl.target : step_q;
			CND_LOOP:     step_d = round_done ? ctl.target : step_q;
			CND_IF_NFULL: step_d = !full_q ? ctl.target : step_q + 1'b1;
			CND_IF_NEND:  step_d = !end_q ? ctl.target : step_q + 1'b1;
			CND_IF_SHORT: step_d = (pos < LEN_ROOM_POS) ? ctl.target : step_q + 1'b1;
			default:      step_d = STEP_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_TAKE;
			full_q  <= 1'b0;
			end_q   <= 1'b0;
			count_q <= '0;
			round_q <= '0;
			chain_q <= '{INIT_A, INIT_B, INIT_C, INIT_D};
			rw_q    <= '{default: '0};
		end else begin
			step_q <= step_d;
			case (ctl.op)
				OP_TAKE: begin
					if (in_acc) begin
						full_q <= s_tuser && (pos == BLOCK_LAST_POS);
						end_q  <= s_tlast;
						if (s_tuser) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				OP_LOAD: begin
					rw_q    <= chain_q;
					round_q <= '0;
				end
				OP_ROUND: begin
					rw_q[0] <= rw_q[3];
					rw_q[1] <= new_b;
					rw_q[2] <= rw_q[1];
					rw_q[3] <= rw_q[2];
					round_q <= round_q + 1'b1;
				end
				OP_ADD: begin
					for (int i = 0; i < 4; i++) begin
						chain_q[i] <= chain_q[i] + rw_q[i];
					end
				end
				OP_EMIT1: begin
					// Restore the initial values once the second half is loaded for output.
					if (out_free) begin
						chain_q <= '{INIT_A, INIT_B, INIT_C, INIT_D};
						count_q <= '0;
						rw_q    <= '{default: '0};
						round_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Block buffer: byte writes, padding, clear and length words.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_TAKE: begin
				if (in_acc && s_tuser) begin
					block_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= s_tdata;
				end
			end
			OP_PAD: begin
				for (int p = 0; p < 64; p++) begin
					if (6'(p) == pos) begin
						block_q[p >> 2][8 * (p & 3) +: 8] <= PAD_BYTE;
					end else if (6'(p) > pos) begin
						block_q[p >> 2][8 * (p & 3) +: 8] <= 8'h00;
					end
				end
			end
			OP_CLEAR: begin
				block_q <= '{default: '0};
			end
			OP_LEN: begin
				block_q[14] <= bit_len[31:0];
				block_q[15] <= bit_len[63:32];
			end
			default: begin
			end
		endcase
	end

	// Output register: hold until taken, load a digest half when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctl.op == OP_EMIT0 || ctl.op == OP_EMIT1) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT0 && out_free) begin
			out_data_q <= {chain_q[1], chain_q[0]};
			out_last_q <= 1'b0;
		end else if (ctl.op == OP_EMIT1 && out_free) begin
			out_data_q <= {chain_q[3], chain_q[2]};
			out_last_q <= 1'b1;
		end
	end

	`MD5DE_CHECK_NEXT(a_round_to_add, (ctl.op == OP_ROUND) && round_done, ctl.op == OP_ADD, "round loop did not end in chain add")
	`MD5DE_CHECK_NOW(a_idle_round_zero, s_tready, round_q == 6'd0, "round counter not at zero while taking items")
	`MD5DE_CHECK_NEXT(a_reinit, (ctl.op == OP_EMIT1) && out_free, (chain_q[0] == INIT_A) && (count_q == '0), "engine not reinitialized after digest")
	`MD5DE_CHECK_NOW(a_step_range, 1'b1, step_q <= STEP_LAST, "step counter outside control program")

endmodule

`default_nettype wire

@@ sim/tb_md5_digest_engine_top.sv @@
// Self-checking testbench for the MD5 digest engine top level.
`timescale 1ns / 1ps

module tb_md5_digest_engine_top;

	// Chaining values that every message starts from.
	localparam logic [31:0] START_A = 32'h67452301;
	localparam logic [31:0] START_B = 32'hEFCDAB89;
	localparam logic [31:0] START_C = 32'h98BADCFE;
	localparam logic [31:0] START_D = 32'h10325476;
	localparam logic [7:0]  MARKER_BYTE = 8'h80;
	localparam int          MSG_ITEMS = 1900;

	typedef struct packed {
		logic [63:0] half;
		logic        last;
	} digest_half_t;

	// Tracks the message in flight and holds the digest halves still owed by the engine.
	class md5_digest_tracker;
		bit [31:0] chain [4];
		bit [31:0] block [16];
		bit [60:0] byte_count;
		bit [31:0] round_k [64];
		bit [4:0]  shift_amt [16];
		digest_half_t owed_halves [$];
		int mismatch_count;

		function new();
			round_k = '{
				32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
				32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
				32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
				32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
				32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
				32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
				32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
				32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
				32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
				32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
				32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
				32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
				32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
				32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
				32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
				32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
			};
			shift_amt = '{
				5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
				5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
			};
			mismatch_count = 0;
			restart();
		endfunction

		function void restart();
			chain[0] = START_A;
			chain[1] = START_B;
			chain[2] = START_C;
			chain[3] = START_D;
			byte_count = '0;
		endfunction

		function void put_byte(input int pos, input bit [7:0] value);
			block[pos / 4][(pos % 4) * 8 +: 8] = value;
		endfunction

		// Run the 64 rounds over the current block and fold into the chain.
		function void compress();
			bit [31:0] a, b, c, d, f, t;
			int g;
			int s;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int r = 0; r < 64; r++) begin
				case (r / 16)
					0: begin
						f = (b & c) | (~b & d);
						g = r;
					end
					1: begin
						f = (d & b) | (~d & c);
						g = 5 * r + 1;
					end
					2: begin
						f = b ^ c ^ d;
						g = 3 * r + 5;
					end
					default: begin
						f = c ^ (b | ~d);
						g = 7 * r;
					end
				endcase
				s = shift_amt[(r / 16) * 4 + (r % 4)];
				t = f + a + round_k[r] + block[g % 16];
				t = (t << s) | (t >> (32 - s));
				a = d;
				d = c;
				c = b;
				b = b + t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		// Note one accepted item; on end of message, pad and queue both digest halves.
		function void take_item(input bit [7:0] data, input bit present, input bit eom);
			int pos;
			bit [63:0] bit_len;
			if (present) begin
				pos = byte_count[5:0];
				put_byte(pos, data);
				byte_count++;
				if (pos == 63)
					compress();
			end
			if (!eom)
				return;
			pos = byte_count[5:0];
			bit_len = {byte_count, 3'b000};
			put_byte(pos, MARKER_BYTE);
			for (int p = pos + 1; p < 64; p++)
				put_byte(p, 8'h00);
			// No room for the length: close this block and start a clean one.
			if (pos >= 56) begin
				compress();
				for (int w = 0; w < 16; w++)
					block[w] = '0;
			end
			block[14] = bit_len[31:0];
			block[15] = bit_len[63:32];
			compress();
			owed_halves.push_back('{half: {chain[1], chain[0]}, last: 1'b0});
			owed_halves.push_back('{half: {chain[3], chain[2]}, last: 1'b1});
			restart();
		endfunction

		function void check_half(input logic [63:0] half, input logic last);
			digest_half_t want;
			if (owed_halves.size() == 0) begin
				$display("%0t: digest half with none owed: expected none, actual %h last %b",
					$time, half, last);
				mismatch_count++;
				return;
			end
			want = owed_halves.pop_front();
			if (half !== want.half) begin
				$display("%0t: digest half: expected %h, actual %h", $time, want.half, half);
				mismatch_count++;
			end
			if (last !== want.last) begin
				$display("%0t: last half flag: expected %b, actual %b", $time, want.last, last);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] byte_present
	logic        s_tlast;   // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [63:0] digest_half
	logic        m_tlast;   // last_half

	md5_digest_tracker tracker;
	int  msg_item_count;
	bit  src_burst;
	bit  sink_burst;

	md5_digest_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Offer one item after a random gap and hold it until the engine takes it.
	// Called at a rising edge; returns at the edge that accepted the item.
	task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= eom;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		tracker.take_item(data, present, eom);
		if (present || eom)
			msg_item_count++;
	endtask

	// Drop valid and hold off until every owed digest half has come back.
	task automatic drain_digests();
		s_tvalid <= 1'b0;
		while (tracker.owed_halves.size() != 0)
			@(posedge clk);
	endtask

	// One message of len bytes with random content, sprinkled with idle items.
	// The close rides on the last byte or comes as an item of its own.
	task automatic send_message(input int len);
		bit close_alone;
		close_alone = (len == 0) || ($urandom_range(0, 2) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, !close_alone && (i == len - 1));
		end
		if (close_alone)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Message length: half the time at the padding and block edges, else short or random.
	function automatic int pick_length();
		int edges [14];
		int roll;
		edges = '{1, 2, 3, 55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return edges[$urandom_range(0, 13)];
		else if (roll < 65)
			return $urandom_range(0, 8);
		else
			return $urandom_range(0, 100);
	endfunction

	// Result side: take each digest half after a random stall and check it.
	initial begin : digest_sink
		int stall;
		m_tready <= 1'b0;
		sink_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			tracker.check_half(m_tdata, m_tlast);
		end
	end

	// Hard stop in case the engine hangs.
	initial begin : watchdog
		#20_000_000;
		$display("tb_md5_digest_engine_top: errors");
		$finish;
	end

	initial begin : stimulus
		tracker = new();
		msg_item_count = 0;
		src_burst = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle item with stray data: must change nothing.
		send_item(8'hFF, 1'b0, 1'b0);
		// Empty message, stray data on the close.
		send_item(8'hA5, 1'b0, 1'b1);
		// "abc", closed on its last byte.
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// Byte extremes, an idle in between, close without a byte.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// Single byte that looks like the pad marker.
		send_item(MARKER_BYTE, 1'b1, 1'b1);
		// Back-to-back empty messages with no gaps.
		src_burst = 1'b1;
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		drain_digests();

		// Random messages until the item budget is spent.
		while (msg_item_count < MSG_ITEMS) begin
			src_burst = ($urandom_range(0, 3) == 0);
			send_message(pick_length());
			if ($urandom_range(0, 7) == 0)
				drain_digests();
		end

		s_tvalid <= 1'b0;
		while (tracker.owed_halves.size() != 0)
			@(posedge clk);
		// Catch any extra digest halves the engine might still push out.
		repeat (300) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("tb_md5_digest_engine_top: clean");
		else
			$display("tb_md5_digest_engine_top: errors");
		$finish;
	end

endmodule
